FILE: design/p2ib_pkg.sv
// ----------------------------------------------------------------------------
// p2ib_pkg
// Shared types and constants of the planar-to-indexed masked blitter.
// ----------------------------------------------------------------------------
package p2ib_pkg;

  // Coordinate and address widths
  localparam int COORD_BITS   = 12;
  localparam int ADDR_BITS    = 24;

  // One byte of each plane per item, one bit per pixel
  localparam int PLANE_BITS   = 8;
  localparam int BITCNT_BITS  = $clog2(PLANE_BITS);
  localparam int INDEX_BITS   = 4;

  // Token queue between front and back
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

  // Configuration register file
  localparam int REG_IDX_BITS = 3;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_DEST_X      = 3'd0,
    REG_DEST_Y      = 3'd1,
    REG_DEST_PITCH  = 3'd2,
    REG_SRC_WIDTH   = 3'd3,
    REG_SRC_HEIGHT  = 3'd4,
    REG_CLIP_WIDTH  = 3'd5,
    REG_CLIP_HEIGHT = 3'd6,
    REG_MASK_ENABLE = 3'd7
  } cfg_reg_t;

  // Reset values of the registers
  localparam logic [COORD_BITS-1:0] RST_DEST_PITCH  = COORD_BITS'(320);
  localparam logic [COORD_BITS-1:0] RST_SRC_WIDTH   = COORD_BITS'(8);
  localparam logic [COORD_BITS-1:0] RST_SRC_HEIGHT  = COORD_BITS'(1);
  localparam logic [COORD_BITS-1:0] RST_CLIP_WIDTH  = COORD_BITS'(4095);
  localparam logic [COORD_BITS-1:0] RST_CLIP_HEIGHT = COORD_BITS'(4095);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] dest_x;
    logic signed [COORD_BITS-1:0] dest_y;
    logic [COORD_BITS-1:0]        dest_pitch;
    logic [COORD_BITS-1:0]        src_width;
    logic [COORD_BITS-1:0]        src_height;
    logic [COORD_BITS-1:0]        clip_width;
    logic [COORD_BITS-1:0]        clip_height;
    logic                         mask_enable;
  } cfg_t;

  // Front-to-back token: a kept pixel, an end-of-item mark, or both
  typedef struct packed {
    logic                  has_pixel;
    logic                  item_end;
    logic [COORD_BITS-1:0] dcol;
    logic [COORD_BITS-1:0] drow;
    logic [INDEX_BITS-1:0] index;
  } token_t;

endpackage

FILE: design/p2ib_pix_in_if.sv
// ----------------------------------------------------------------------------
// p2ib_pix_in_if
// Input channel: one byte of each of the five bit planes per transaction.
// ----------------------------------------------------------------------------
interface p2ib_pix_in_if import p2ib_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PLANE_BITS-1:0] mask_bits;
  logic [PLANE_BITS-1:0] blue_bits;
  logic [PLANE_BITS-1:0] green_bits;
  logic [PLANE_BITS-1:0] red_bits;
  logic [PLANE_BITS-1:0] intensity_bits;

  modport source (
    output valid, mask_bits, blue_bits, green_bits, red_bits, intensity_bits,
    input  ready
  );
  modport sink (
    input  valid, mask_bits, blue_bits, green_bits, red_bits, intensity_bits,
    output ready
  );
endinterface

FILE: design/p2ib_pix_out_if.sv
// ----------------------------------------------------------------------------
// p2ib_pix_out_if
// Output channel: one destination pixel write per transaction.
// ----------------------------------------------------------------------------
interface p2ib_pix_out_if import p2ib_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ADDR_BITS-1:0]  dest_address;
  logic [INDEX_BITS-1:0] pixel_index;
  logic                  last_of_item;

  modport source (
    output valid, dest_address, pixel_index, last_of_item,
    input  ready
  );
  modport sink (
    input  valid, dest_address, pixel_index, last_of_item,
    output ready
  );
endinterface

FILE: design/p2ib_cfg_if.sv
// ----------------------------------------------------------------------------
// p2ib_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface p2ib_cfg_if import p2ib_pkg::*; ();
  logic                  valid;
  logic                  ready;
  cfg_reg_t              index;
  logic [COORD_BITS-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

FILE: design/planar_to_indexed_masked_blit_top.sv
// ----------------------------------------------------------------------------
// planar_to_indexed_masked_blit_top
// Four-plane masked sprite to 4-bit indexed pixels with pitched addressing.
//
//   Channel  Role  Payload                                            Per transaction
//   cfg      sink  index, data                                        one register write
//   pix_in   sink  mask/blue/green/red/intensity_bits                 eight source pixels
//   pix_out  src   dest_address, pixel_index, last_of_item            one destination write
//
// An input item occupies the pixel walker for its eight pixels, one source
// pixel per cycle while the token queue has room; the next item is taken in
// the cycle the last pixel is walked. Writes leave at up to one per cycle.
// rst is synchronous; it restores the register defaults and the source
// position. A stalled output fills the token queue and then holds the walker.
// ----------------------------------------------------------------------------
module planar_to_indexed_masked_blit_top import p2ib_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  p2ib_cfg_if.sink       cfg,
  p2ib_pix_in_if.sink    pix_in,
  p2ib_pix_out_if.source pix_out
);

  cfg_t   regs;

  logic   f_tok_valid;
  logic   f_tok_ready;
  token_t f_tok;
  logic   b_tok_valid;
  logic   b_tok_ready;
  token_t b_tok;

  // Register file
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dest_x      <= '0;
      regs.dest_y      <= '0;
      regs.dest_pitch  <= RST_DEST_PITCH;
      regs.src_width   <= RST_SRC_WIDTH;
      regs.src_height  <= RST_SRC_HEIGHT;
      regs.clip_width  <= RST_CLIP_WIDTH;
      regs.clip_height <= RST_CLIP_HEIGHT;
      regs.mask_enable <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DEST_X:      regs.dest_x      <= cfg.data;
        REG_DEST_Y:      regs.dest_y      <= cfg.data;
        REG_DEST_PITCH:  regs.dest_pitch  <= cfg.data;
        REG_SRC_WIDTH:   regs.src_width   <= cfg.data;
        REG_SRC_HEIGHT:  regs.src_height  <= cfg.data;
        REG_CLIP_WIDTH:  regs.clip_width  <= cfg.data;
        REG_CLIP_HEIGHT: regs.clip_height <= cfg.data;
        REG_MASK_ENABLE: regs.mask_enable <= cfg.data[0];
        default:         regs             <= regs;
      endcase
    end
  end

  // Pixel walker
  p2ib_front u_front (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .pix_in    (pix_in),
    .tok_valid (f_tok_valid),
    .tok_ready (f_tok_ready),
    .tok       (f_tok)
  );

  // Token queue
  p2ib_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_tok_valid),
    .push_ready (f_tok_ready),
    .push_tok   (f_tok),
    .pop_valid  (b_tok_valid),
    .pop_ready  (b_tok_ready),
    .pop_tok    (b_tok)
  );

  // Address back end
  p2ib_back u_back (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .tok_valid (b_tok_valid),
    .tok_ready (b_tok_ready),
    .tok       (b_tok),
    .pix_out   (pix_out)
  );

endmodule

FILE: design/p2ib_front.sv
// ----------------------------------------------------------------------------
// p2ib_front
// Takes a plane byte group, walks its eight pixels one per cycle while the
// queue has room, tracks source column/row, marks pixels written or dropped.
// ----------------------------------------------------------------------------
module p2ib_front import p2ib_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              regs,
  p2ib_pix_in_if.sink       pix_in,
  output logic              tok_valid,
  input  logic              tok_ready,
  output token_t            tok
);

  localparam int DW = COORD_BITS + 2;

  logic                   busy;
  logic [BITCNT_BITS-1:0] bit_cnt;
  logic [PLANE_BITS-1:0]  mask_sr;
  logic [PLANE_BITS-1:0]  blue_sr;
  logic [PLANE_BITS-1:0]  green_sr;
  logic [PLANE_BITS-1:0]  red_sr;
  logic [PLANE_BITS-1:0]  inten_sr;
  logic [COORD_BITS-1:0]  source_column;
  logic [COORD_BITS-1:0]  source_row;

  logic                   step;
  logic                   last_step;
  logic                   accept;
  logic                   sprite_done;
  logic                   col_over;
  logic                   active;
  logic signed [DW-1:0]   dcol;
  logic signed [DW-1:0]   drow;
  logic                   in_clip;
  logic                   keep;
  logic [COORD_BITS-1:0]  col_inc;
  logic [COORD_BITS-1:0]  row_inc;

  // Step handshake: one pixel per cycle while the queue has room
  assign step         = busy && tok_ready;
  assign last_step    = (bit_cnt == BITCNT_BITS'(PLANE_BITS - 1));
  assign pix_in.ready = !busy || (step && last_step);
  assign accept       = pix_in.valid && pix_in.ready;

  // Pixel classification
  assign sprite_done = (source_row >= regs.src_height);
  assign col_over    = (source_column >= regs.src_width);
  assign active      = !sprite_done && !col_over;

  assign dcol = $signed({2'b00, source_column}) +
                $signed({{2{regs.dest_x[COORD_BITS-1]}}, regs.dest_x});
  assign drow = $signed({2'b00, source_row}) +
                $signed({{2{regs.dest_y[COORD_BITS-1]}}, regs.dest_y});

  assign in_clip = !dcol[DW-1] && !drow[DW-1] &&
                   (dcol[DW-2:0] < {1'b0, regs.clip_width}) &&
                   (drow[DW-2:0] < {1'b0, regs.clip_height});
  assign keep    = active && in_clip && !(regs.mask_enable && mask_sr[PLANE_BITS-1]);

  assign col_inc = source_column + COORD_BITS'(1);
  assign row_inc = source_row + COORD_BITS'(1);

  // Token to the queue: kept pixel and/or end-of-item mark
  assign tok_valid     = step && (keep || last_step);
  assign tok.has_pixel = keep;
  assign tok.item_end  = last_step;
  assign tok.dcol      = dcol[COORD_BITS-1:0];
  assign tok.drow      = drow[COORD_BITS-1:0];
  assign tok.index     = {inten_sr[PLANE_BITS-1], red_sr[PLANE_BITS-1],
                          green_sr[PLANE_BITS-1], blue_sr[PLANE_BITS-1]};

  // Item control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_cnt <= '0;
    end else if (accept) begin
      busy    <= 1'b1;
      bit_cnt <= '0;
    end else if (step) begin
      bit_cnt <= bit_cnt + BITCNT_BITS'(1);
      if (last_step) begin
        busy <= 1'b0;
      end
    end
  end

  // Plane shift registers, current pixel at the MSB
  always_ff @(posedge clk) begin
    if (accept) begin
      mask_sr  <= pix_in.mask_bits;
      blue_sr  <= pix_in.blue_bits;
      green_sr <= pix_in.green_bits;
      red_sr   <= pix_in.red_bits;
      inten_sr <= pix_in.intensity_bits;
    end else if (step) begin
      mask_sr  <= {mask_sr[PLANE_BITS-2:0], 1'b0};
      blue_sr  <= {blue_sr[PLANE_BITS-2:0], 1'b0};
      green_sr <= {green_sr[PLANE_BITS-2:0], 1'b0};
      red_sr   <= {red_sr[PLANE_BITS-2:0], 1'b0};
      inten_sr <= {inten_sr[PLANE_BITS-2:0], 1'b0};
    end
  end

  // Source position; holds once the sprite is finished
  always_ff @(posedge clk) begin
    if (rst) begin
      source_column <= '0;
      source_row    <= '0;
    end else if (step && !sprite_done) begin
      if (col_over || (col_inc >= regs.src_width)) begin
        source_column <= '0;
        source_row    <= row_inc;
      end else begin
        source_column <= col_inc;
      end
    end
  end

endmodule

FILE: design/p2ib_queue.sv
// ----------------------------------------------------------------------------
// p2ib_queue
// Small token FIFO decoupling the pixel walker from the address back end.
// ----------------------------------------------------------------------------
module p2ib_queue import p2ib_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  token_t push_tok,
  output logic   pop_valid,
  input  logic   pop_ready,
  output token_t pop_tok
);

  token_t               slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count != (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_tok    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (QPTR_BITS+1)'(1);
        2'b01:   count <= count - (QPTR_BITS+1)'(1);
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

endmodule

FILE: design/p2ib_back.sv
// ----------------------------------------------------------------------------
// p2ib_back
// Forms destination addresses (row * pitch + column) and issues writes.
// A one-entry hold stage keeps each pixel until its own end-of-item mark or
// the next token shows whether it is the final write of its item.
// ----------------------------------------------------------------------------
module p2ib_back import p2ib_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               regs,
  input  logic               tok_valid,
  output logic               tok_ready,
  input  token_t             tok,
  p2ib_pix_out_if.source     pix_out
);

  localparam int PROD_BITS = 2 * COORD_BITS;
  localparam int SUM_BITS  = (PROD_BITS + 1 > ADDR_BITS) ? PROD_BITS + 1 : ADDR_BITS;

  // Multiply stage
  logic                  mul_valid;
  token_t                mul_tok;
  logic [PROD_BITS-1:0]  mul_prod;
  logic                  mul_ready;

  // Hold stage
  logic                  hold_valid;
  logic                  hold_final;
  logic [ADDR_BITS-1:0]  hold_addr;
  logic [INDEX_BITS-1:0] hold_index;

  logic                  out_space;
  logic                  take;
  logic                  emit;
  logic                  emit_last;
  logic [SUM_BITS-1:0]   addr_sum;

  assign out_space = !pix_out.valid || pix_out.ready;
  assign take      = mul_valid && (!hold_valid || out_space);
  assign emit      = hold_valid && out_space && (hold_final || mul_valid);
  assign emit_last = hold_final || !mul_tok.has_pixel;
  assign mul_ready = !mul_valid || take;
  assign tok_ready = mul_ready;
  assign addr_sum  = SUM_BITS'(mul_prod) + SUM_BITS'(mul_tok.dcol);

  // Row times pitch
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (mul_ready) begin
      mul_valid <= tok_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready && tok_valid) begin
      mul_tok  <= tok;
      mul_prod <= PROD_BITS'(tok.drow) * PROD_BITS'(regs.dest_pitch);
    end
  end

  // Hold stage: released once its last flag is known
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      hold_final <= 1'b0;
    end else if (take) begin
      hold_valid <= mul_tok.has_pixel;
      hold_final <= mul_tok.item_end;
    end else if (emit) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_addr  <= addr_sum[ADDR_BITS-1:0];
      hold_index <= mul_tok.index;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (emit) begin
      pix_out.valid <= 1'b1;
    end else if (pix_out.ready) begin
      pix_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pix_out.dest_address <= hold_addr;
      pix_out.pixel_index  <= hold_index;
      pix_out.last_of_item <= emit_last;
    end
  end

endmodule
